/* sv/fdl_pkg.sv */
// Shared widths and types for the fractional delay line.
`timescale 1ns / 1ps
`default_nettype none

package fdl_pkg;

  // Fixed widths of the sample and delay words.
  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned DELAY_W  = 21;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // Status of one pair of store reads travelling down the pipeline.
  typedef struct packed {
    logic vld;   // stage holds a word
    logic ok_a;  // newer tap slot has been written since reset
    logic ok_b;  // older tap slot has been written since reset
  } rd_ctl_t;

endpackage

`default_nettype wire

/* sv/fdl_store.sv */
// Sample store: one write port and two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module fdl_store import fdl_pkg::*; #(
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     rd_en_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire sample_t                  wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output sample_t                       rdata_a_o,
  output sample_t                       rdata_b_o
);

  sample_t mem_q [DEPTH];
  sample_t rdata_a_q;
  sample_t rdata_b_q;

  // Write port. A read of the same slot in the same cycle returns the old word.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Two read ports with registered data; the data holds while the pipe is frozen.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire

/* sv/fdl_interp.sv */
// Interpolation datapath: tap difference, fraction multiply and final add.
`timescale 1ns / 1ps
`default_nettype none

module fdl_interp import fdl_pkg::*; #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire rd_ctl_t              ctl_i,
  input  wire logic [FRAC_BITS-1:0] frac_i,
  input  wire sample_t              rd_a_i,
  input  wire sample_t              rd_b_i,
  output logic                      res_valid_o,
  output sample_t                   res_o
);

  localparam int unsigned DW = SAMPLE_W + 1;
  localparam int unsigned PW = DW + FRAC_BITS + 1;

  sample_t                 first;
  sample_t                 second;
  logic signed [DW-1:0]    diff_d;
  logic                    v3_q;
  sample_t                 base3_q;
  logic signed [DW-1:0]    diff3_q;
  logic [FRAC_BITS-1:0]    frac3_q;
  logic                    v4_q;
  sample_t                 base4_q;
  logic signed [PW-1:0]    prod4_q;
  logic signed [PW-1:0]    shifted;

  // Slots never written since reset read as zero.
  assign first  = ctl_i.ok_a ? rd_a_i : '0;
  assign second = ctl_i.ok_b ? rd_b_i : '0;
  assign diff_d = {second[SAMPLE_W-1], second} - {first[SAMPLE_W-1], first};

  // Valid bits of the two arithmetic stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= ctl_i.vld;
      v4_q <= v3_q;
    end
  end

  // Difference stage, then multiply stage.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      base3_q <= first;
      diff3_q <= diff_d;
      frac3_q <= frac_i;
      base4_q <= base3_q;
      prod4_q <= $signed({1'b0, frac3_q}) * diff3_q;
    end
  end

  // Arithmetic shift floors the product. The sum always lies between the two
  // taps, so the low bits of the sum are the exact result.
  assign shifted     = prod4_q >>> FRAC_BITS;
  assign res_o       = base4_q + shifted[SAMPLE_W-1:0];
  assign res_valid_o = v4_q;

endmodule

`default_nettype wire

/* sv/fdl_outbuf.sv */
// Output register with one skid entry between the pipeline and the receiver.
`timescale 1ns / 1ps
`default_nettype none

module fdl_outbuf import fdl_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  input  wire sample_t in_data_i,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output sample_t      out_data_o,
  output logic         full_o
);

  logic    out_v_q;
  sample_t out_d_q;
  logic    skid_v_q;
  sample_t skid_d_q;

  // Occupancy. While the skid entry holds a word, the pipeline is frozen.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (!out_stall_i) begin
        skid_v_q <= 1'b0;
      end
    end else if (out_v_q && out_stall_i) begin
      if (in_valid_i) begin
        skid_v_q <= 1'b1;
      end
    end else begin
      out_v_q <= in_valid_i;
    end
  end

  // Data registers follow the same moves.
  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (!out_stall_i) begin
        out_d_q <= skid_d_q;
      end
    end else if (out_v_q && out_stall_i) begin
      if (in_valid_i) begin
        skid_d_q <= in_data_i;
      end
    end else begin
      out_d_q <= in_data_i;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_d_q;
  assign full_o      = skid_v_q;

  // The skid entry only fills behind a word that is waiting at the output.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid entry holds a word while the output register is empty");

endmodule

`default_nettype wire

/* sv/fractional_delay_line_core.sv */
// Linear-interpolated fractional delay line, top level.
//
// Input channel: in_valid_i / in_stall_o carry one word made of a signed audio
// sample and a signed delay with FRAC_BITS fraction bits. The delay is clamped
// to 0 .. DEPTH-1 samples. Output channel: out_valid_o / out_stall_i carry the
// interpolated sample. Every accepted word gives exactly one result, in order.
// Throughput is one word per cycle while in_stall_o is low: the sample store
// does both tap reads and the write of the new sample in the same cycle through
// two read ports and one write port. An accepted word passes the input, store
// read, difference and multiply stages before it loads the output register.
// After reset the store contents are not cleared; a write pointer and a wrap
// flag mark which slots have been written, and unwritten slots read as zero,
// so the block accepts words from the first cycle after reset.
// When the receiver stalls, the result waits in the output register and the
// pipeline keeps moving; one more result lands in a skid entry, and only then
// does in_stall_o rise and the whole pipeline hold until the receiver drains.
`timescale 1ns / 1ps
`default_nettype none

module fractional_delay_line_core import fdl_pkg::*; #(
  parameter int unsigned DEPTH     = 4096,
  parameter int unsigned FRAC_BITS = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [SAMPLE_W-1:0] sample_in_i,
  input  wire logic [DELAY_W-1:0]  delay_q8_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [SAMPLE_W-1:0]     sample_out_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned IW = DELAY_W - 1;
  localparam int unsigned CW = ((IW > AW + FRAC_BITS) ? IW : AW + FRAC_BITS) + 1;
  localparam logic [CW-1:0] MAX_DELAY = CW'(DEPTH - 1) << FRAC_BITS;
  localparam logic [AW-1:0] PTR_LAST  = AW'(DEPTH - 1);
  localparam logic [AW:0]   DEPTH_X   = (AW + 1)'(DEPTH);

  logic                 en;
  logic                 full;
  logic [CW-1:0]        dly_mag;
  logic [AW-1:0]        dint_d;
  logic [FRAC_BITS-1:0] frac_d;
  logic                 s1_v_q;
  sample_t              s1_sample_q;
  logic [AW-1:0]        s1_dint_q;
  logic [FRAC_BITS-1:0] s1_frac_q;
  logic [AW-1:0]        wr_ptr_q;
  logic                 wrapped_q;
  logic                 wr_en;
  logic [AW:0]          diff_a;
  logic [AW:0]          diff_b;
  logic [AW-1:0]        rd_addr_a;
  logic [AW-1:0]        rd_addr_b;
  logic                 ok_a;
  logic                 ok_b;
  rd_ctl_t              s2_ctl_q;
  logic [FRAC_BITS-1:0] s2_frac_q;
  sample_t              rd_a;
  sample_t              rd_b;
  logic                 res_valid;
  sample_t              res;
  sample_t              out_data;

  // The whole pipeline advances unless the skid entry is occupied.
  assign en         = !full;
  assign in_stall_o = full;

  // Clamp the delay: negative goes to zero, overlarge saturates to DEPTH-1 whole samples.
  always_comb begin
    dly_mag = CW'(delay_q8_i[IW-1:0]);
    if (delay_q8_i[DELAY_W-1]) begin
      dint_d = '0;
      frac_d = '0;
    end else if (dly_mag > MAX_DELAY) begin
      dint_d = PTR_LAST;
      frac_d = '0;
    end else begin
      dint_d = AW'(dly_mag >> FRAC_BITS);
      frac_d = dly_mag[FRAC_BITS-1:0];
    end
  end

  // Input stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_sample_q <= sample_t'(sample_in_i);
      s1_dint_q   <= dint_d;
      s1_frac_q   <= frac_d;
    end
  end

  // Tap addresses, wrapped modulo DEPTH. The older tap is one slot further back.
  // Before the first wrap only slots below the write pointer hold written words.
  always_comb begin
    diff_a    = {1'b0, wr_ptr_q} - {1'b0, s1_dint_q};
    diff_b    = {1'b0, wr_ptr_q} + ~{1'b0, s1_dint_q};
    rd_addr_a = diff_a[AW] ? AW'(diff_a + DEPTH_X) : diff_a[AW-1:0];
    rd_addr_b = diff_b[AW] ? AW'(diff_b + DEPTH_X) : diff_b[AW-1:0];
    ok_a      = wrapped_q || (s1_dint_q != '0 && !diff_a[AW]);
    ok_b      = wrapped_q || !diff_b[AW];
  end

  assign wr_en = en && s1_v_q;

  // Write pointer and wrap flag; they move with each write into the store.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q  <= '0;
      wrapped_q <= 1'b0;
    end else if (wr_en) begin
      if (wr_ptr_q == PTR_LAST) begin
        wr_ptr_q  <= '0;
        wrapped_q <= 1'b1;
      end else begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
    end
  end

  // Read stage control, aligned with the registered store data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_ctl_q <= '0;
    end else if (en) begin
      s2_ctl_q <= '{vld: s1_v_q, ok_a: ok_a, ok_b: ok_b};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_frac_q <= s1_frac_q;
    end
  end

  fdl_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .rd_en_i   (en),
    .we_i      (wr_en),
    .waddr_i   (wr_ptr_q),
    .wdata_i   (s1_sample_q),
    .raddr_a_i (rd_addr_a),
    .raddr_b_i (rd_addr_b),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  fdl_interp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_interp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .ctl_i       (s2_ctl_q),
    .frac_i      (s2_frac_q),
    .rd_a_i      (rd_a),
    .rd_b_i      (rd_b),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  fdl_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_valid),
    .in_data_i   (res),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data),
    .full_o      (full)
  );

  assign sample_out_o = out_data;

  // Tap addresses stay inside the store for any depth.
  a_taps_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q |-> ({1'b0, rd_addr_a} < DEPTH_X) && ({1'b0, rd_addr_b} < DEPTH_X))
    else $error("tap address beyond the store depth");

  // Writing the last slot wraps the pointer and marks the store as filled.
  a_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && wr_ptr_q == PTR_LAST) |=> (wrapped_q && wr_ptr_q == '0))
    else $error("write pointer did not wrap after the last slot");

  // Every other write moves the pointer by exactly one.
  a_ptr_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && wr_ptr_q != PTR_LAST) |=> (wr_ptr_q == $past(wr_ptr_q) + 1'b1))
    else $error("write pointer did not advance by one");

  // A frozen pipeline keeps its read-stage contents.
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(s2_ctl_q))
    else $error("read stage changed while the pipeline was held");

endmodule

`default_nettype wire

/* test/tb_fdl_score_pkg.sv */
// Scoreboard for the fractional delay line: tap predictor and expected-sample queue.
`timescale 1ns / 1ps

package tb_fdl_score_pkg;
  import fdl_pkg::*;

  localparam int unsigned STORE_DEPTH = 4096;
  localparam int unsigned FRAC_W      = 8;
  localparam int unsigned INDEX_W     = $clog2(STORE_DEPTH);
  localparam longint      MAX_DELAY_Q = longint'(STORE_DEPTH - 1) << FRAC_W;

  typedef logic signed [DELAY_W-1:0] delay_t;

  class delay_line_scoreboard;
    sample_t            history[STORE_DEPTH];
    bit [INDEX_W-1:0]   wr_ptr;
    sample_t            expected_q[$];
    int unsigned        mismatches;
    int unsigned        matched;
    int unsigned        words_in;
    int unsigned        clamp_low;
    int unsigned        clamp_high;
    int unsigned        zero_whole;
    int unsigned        deepest_tap;

    function new();
      foreach (history[i]) history[i] = '0;
      wr_ptr      = '0;
      mismatches  = 0;
      matched     = 0;
      words_in    = 0;
      clamp_low   = 0;
      clamp_high  = 0;
      zero_whole  = 0;
      deepest_tap = 0;
    endfunction

    // Predict the interpolated sample for one accepted word, then store the new sample.
    function void note_input(sample_t smp, delay_t dly);
      longint           d;
      int unsigned      whole;
      longint           frac;
      bit [INDEX_W-1:0] tap_a;
      bit [INDEX_W-1:0] tap_b;
      longint           s_a;
      longint           s_b;
      longint           prod;
      longint           res;

      d = longint'(dly);
      if (d < 0) begin
        d = 0;
        clamp_low++;
      end
      if (d > MAX_DELAY_Q) begin
        d = MAX_DELAY_Q;
        clamp_high++;
      end
      whole = int'(d >> FRAC_W);
      frac  = d & ((longint'(1) << FRAC_W) - 1);
      if (whole == 0) zero_whole++;
      if (whole > deepest_tap) deepest_tap = whole;

      // The newer tap counts back from the write slot; the older tap is one further back.
      tap_a = wr_ptr - whole[INDEX_W-1:0];
      tap_b = tap_a - 1'b1;
      s_a   = longint'(history[tap_a]);
      s_b   = longint'(history[tap_b]);
      prod  = frac * (s_b - s_a);
      res   = s_a + (prod >>> FRAC_W);
      expected_q.push_back(sample_t'(res));

      history[wr_ptr] = smp;
      wr_ptr++;
      words_in++;
    endfunction

    // Compare one delivered sample with the oldest prediction.
    function void check_result(logic [SAMPLE_W-1:0] got);
      sample_t want;
      if (expected_q.size() == 0) begin
        $error("sample_out: no word expected, actual %0d", $signed(got));
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
        $error("sample_out: expected %0d, actual %0d", want, $signed(got));
        mismatches++;
      end else begin
        matched++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

/* test/tb_top.sv */
// Top-level testbench for the fractional delay line core.
`timescale 1ns / 1ps

module tb_top;
  import fdl_pkg::*;
  import tb_fdl_score_pkg::*;

  localparam int unsigned  RANDOM_WORDS = 1750;
  localparam int unsigned  HOLD_CYCLES  = 80;
  localparam int unsigned  HOLD_AT      = 600;
  localparam int unsigned  DRAIN_AT     = 1200;
  localparam int unsigned  SETTLE_CYC   = 12;
  localparam longint       WATCHDOG_NS  = 2_000_000;
  localparam sample_t      SMP_MAX      = 24'sh7FFFFF;
  localparam sample_t      SMP_MIN      = 24'sh800000;
  localparam delay_t       DLY_MAX      = 21'sh0FFFFF;
  localparam delay_t       DLY_MIN      = 21'sh100000;
  localparam delay_t       DLY_SAT      = delay_t'(MAX_DELAY_Q);
  localparam delay_t       ONE_SAMPLE   = delay_t'(1 << FRAC_W);

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    in_valid = 1'b0;
  sample_t sample_in = '0;
  delay_t  delay_q8 = '0;
  logic    out_stall = 1'b0;
  logic    in_stall;
  logic    out_valid;
  logic [SAMPLE_W-1:0] sample_out;

  logic        hold_req = 1'b0;
  int unsigned backpressure_cycles = 0;
  delay_line_scoreboard sb;

  fractional_delay_line_core u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .sample_in_i  (sample_in),
    .delay_q8_i   (delay_q8),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .sample_out_o (sample_out)
  );

  always #5 clk = ~clk;

  // Offer one word at the falling edge and hold it until the core takes it.
  task automatic send_word(input sample_t smp, input delay_t dly);
    @(negedge clk);
    in_valid  <= 1'b1;
    sample_in <= smp;
    delay_q8  <= dly;
    do @(posedge clk); while (in_stall);
    sb.note_input(smp, dly);
  endtask

  // Leave the input channel empty for a number of cycles.
  task automatic idle_cycles(input int unsigned n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Mostly extreme or random sample values.
  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0:       return SMP_MAX;
      1:       return SMP_MIN;
      2:       return ($urandom_range(0, 1) == 0) ? sample_t'(0) : sample_t'(-1);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Short delays that hit recent samples most often, plus clamped and full-range ones.
  function automatic delay_t pick_delay(input int unsigned written);
    int unsigned r;
    int unsigned whole;
    int unsigned reach;
    r     = $urandom_range(0, 99);
    reach = (written > STORE_DEPTH - 1) ? STORE_DEPTH - 1 : written;
    if (r < 45) begin
      whole = $urandom_range(0, 24);
      return delay_t'((whole << FRAC_W) | $urandom_range(0, 255));
    end else if (r < 60) begin
      whole = $urandom_range(0, reach);
      return delay_t'((whole << FRAC_W) | $urandom_range(0, 255));
    end else if (r < 70) begin
      return delay_t'(-int'($urandom_range(1, 1 << (DELAY_W - 1))));
    end else if (r < 80) begin
      return delay_t'($urandom_range(int'(MAX_DELAY_Q) + 1, (1 << (DELAY_W - 1)) - 1));
    end else if (r < 92) begin
      return delay_t'($urandom);
    end
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return DLY_SAT;
      2:       return delay_t'((1 << FRAC_W) - 1);
      default: return DLY_SAT - 21'sd1;
    endcase
  endfunction

  // Check every word the core delivers.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(sample_out);
    end
  end

  // Count cycles in which the core pushes back on an offered word.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_stall) begin
      backpressure_cycles++;
    end
  end

  // Receiver stall pattern: spans of free flow, light, heavy and periodic stalls.
  initial begin
    int unsigned mode;
    int unsigned span;
    int unsigned period;
    forever begin
      mode   = $urandom_range(0, 3);
      span   = $urandom_range(20, 200);
      period = $urandom_range(2, 7);
      for (int unsigned i = 0; i < span; i++) begin
        @(negedge clk);
        if (hold_req) begin
          // Long hold-off so the pipeline and skid entry fill up.
          hold_req = 1'b0;
          out_stall <= 1'b1;
          repeat (HOLD_CYCLES - 1) @(negedge clk);
        end else begin
          case (mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 9) < 3);
            2:       out_stall <= ($urandom_range(0, 9) < 7);
            default: out_stall <= ((i % period) == 0);
          endcase
        end
      end
    end
  end

  // Run limit.
  initial begin
    #(WATCHDOG_NS);
    $display("CHECKS FAILED");
    $finish;
  end

  // Stimulus.
  initial begin
    int unsigned sent;
    int unsigned burst;
    bit          hold_done;
    bit          drain_done;

    sb = new();
    sent       = 0;
    hold_done  = 1'b0;
    drain_done = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Directed words: sample extremes, clamping, zero and full-scale taps.
    send_word(SMP_MAX, '0);
    send_word(SMP_MIN, ONE_SAMPLE);
    send_word('0, ONE_SAMPLE | 21'sd128);
    send_word(sample_t'(-1), ONE_SAMPLE | 21'sd255);
    send_word(SMP_MAX, (ONE_SAMPLE << 1) | 21'sd1);
    send_word(SMP_MIN, delay_t'(-1));
    send_word(sample_t'(1), DLY_MIN);
    send_word(SMP_MAX, 21'sd128);
    send_word(SMP_MIN, 21'sd255);
    send_word(SMP_MAX, DLY_SAT);
    send_word(SMP_MIN, DLY_SAT + 21'sd1);
    send_word(sample_t'(-1), DLY_MAX);
    send_word('0, DLY_SAT - 21'sd1);
    send_word(sample_t'(123456), (ONE_SAMPLE * 21'sd3) | 21'sh55);
    send_word(sample_t'(-654321), (ONE_SAMPLE * 21'sd4) | 21'shAA);
    send_word(SMP_MIN, (ONE_SAMPLE * 21'sd5) | 21'sd255);
    send_word(SMP_MAX, (ONE_SAMPLE * 21'sd9) | 21'sd1);
    send_word(sample_t'(-2), '0);
    idle_cycles(3);

    // Random words in bursts with random gaps.
    while (sent < RANDOM_WORDS) begin
      if (!hold_done && sent >= HOLD_AT) begin
        // Back-to-back words against a long receiver hold-off.
        hold_done = 1'b1;
        hold_req  = 1'b1;
        for (int unsigned k = 0; k < 40; k++) begin
          send_word(pick_sample(), pick_delay(sb.words_in));
          sent++;
        end
      end
      if (!drain_done && sent >= DRAIN_AT) begin
        // Pause until every outstanding word has come back.
        drain_done = 1'b1;
        idle_cycles(1);
        while (sb.pending() != 0) @(posedge clk);
      end
      burst = $urandom_range(1, 48);
      for (int unsigned k = 0; k < burst && sent < RANDOM_WORDS; k++) begin
        send_word(pick_sample(), pick_delay(sb.words_in));
        sent++;
      end
      if ($urandom_range(0, 3) != 0) begin
        idle_cycles($urandom_range(1, 10));
      end
    end
    idle_cycles(1);

    // Drain, then allow a few more cycles for any stray word.
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);

    $display("Run covered %0d words, %0d checked; %0d negative and %0d overlarge delays clamped.",
             sb.words_in, sb.matched, sb.clamp_low, sb.clamp_high);
    $display("Zero whole delay %0d times, deepest tap %0d, input stalled %0d cycles.",
             sb.zero_whole, sb.deepest_tap, backpressure_cycles);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/fdl_pkg.sv
sv/fdl_store.sv
sv/fdl_interp.sv
sv/fdl_outbuf.sv
sv/fractional_delay_line_core.sv
test/tb_fdl_score_pkg.sv
test/tb_top.sv
